[rtl/lsfb_pkg.sv]
package lsfb_pkg;

	localparam int unsigned LEN_W     = 11;
	localparam int unsigned LEN_LIMIT = (1 << LEN_W) - 1;
	localparam int unsigned HDR_LEN   = 58;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CRC_FROM  = 8;
	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned CMD_PTR_W = 2;
	localparam int unsigned CMD_CNT_W = 3;

	localparam logic [7:0]  TAIL_BYTE = 8'h5A;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] F2_OFFSET = 16'd27;
	localparam logic [15:0] F1_OFFSET = 16'd9;

	localparam logic [IDX_W-1:0] IDX_F1_LO  = 6'd20;
	localparam logic [IDX_W-1:0] IDX_F1_HI  = 6'd21;
	localparam logic [IDX_W-1:0] IDX_F2_LO  = 6'd29;
	localparam logic [IDX_W-1:0] IDX_F2_HI  = 6'd30;
	localparam logic [IDX_W-1:0] IDX_LEN_LO = 6'd54;
	localparam logic [IDX_W-1:0] IDX_LEN_HI = 6'd55;
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(HDR_LEN - 1);

	localparam logic [7:0] HDR_TEMPLATE [HDR_LEN] = '{
		8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'h01, 8'h00,
		8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h02,
		8'h00, 8'h00, 8'hA3, 8'h06, 8'h01, 8'h2D, 8'h00, 8'h00, 8'h01, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h00, 8'h20, 8'h01, 8'h30, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02,
		8'h03, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic {
		CMD_START,
		CMD_DATA
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [LEN_W-1:0] len;
		logic [7:0]       data;
		logic             last;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HDR,
		BK_CRC_LO,
		BK_CRC_HI,
		BK_TAIL
	} back_state_t;

	// Reflected CRC-16, one byte per call.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Header byte at a given offset with the length fields patched in.
	function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
	                                        input logic [LEN_W-1:0] len);
		logic [15:0] f2;
		logic [15:0] f1;
		logic [7:0]  b;
		f2 = 16'(len) + F2_OFFSET;
		f1 = f2 + F1_OFFSET;
		case (idx)
			IDX_F1_LO:  b = f1[7:0];
			IDX_F1_HI:  b = f1[15:8];
			IDX_F2_LO:  b = f2[7:0];
			IDX_F2_HI:  b = f2[15:8];
			IDX_LEN_LO: b = len[7:0];
			IDX_LEN_HI: b = 8'(len[LEN_W-1:8]);
			default: begin
				if (32'(idx) < HDR_LEN) begin
					b = HDR_TEMPLATE[idx];
				end else begin
					b = 8'h00;
				end
			end
		endcase
		return b;
	endfunction

endpackage

[rtl/led_sign_frame_builder_crc16_core.sv]
// With the back part idle and the queue empty, a transaction's first result byte passes through
// the command queue and then the output register before it reaches the result ports.
// Throughput: one result byte per cycle from the output register while it is popped; a payload
// byte gives one result byte, a start gives 58 header bytes (61 at zero length), and a closing
// byte adds 3 for CRC and tail, so the rate of transactions is set by the number of result bytes.
// Reset: arst_n is asynchronous and active low; it empties the command queue and the output
// register and returns both parts to idle with no frame open.
module led_sign_frame_builder_crc16_core #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       action,
	input  logic [lsfb_pkg::LEN_W-1:0] payload_length,
	input  logic [7:0]                 data_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       frame_end
);
	import lsfb_pkg::*;

	// The front part tracks the open frame and its remaining payload count. It saturates
	// the length, drops data that arrives with no frame open, and marks the payload byte
	// that closes the frame. Each kept transaction becomes one command in a short queue.
	cmd_t fe_cmd;
	logic fe_push;
	logic q_full;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	// Input stalls only when the command queue is full; the back part may be busy
	// with a long header while further commands wait.
	assign full = q_full;

	lsfb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.fifo_full     (q_full),
		.action        (action),
		.payload_length(payload_length),
		.data_byte     (data_byte),
		.cmd_push      (fe_push),
		.cmd           (fe_cmd)
	);

	lsfb_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_push),
		.wr_cmd  (fe_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_cmd  (q_cmd)
	);

	// The back part is a byte sequencer: it walks the header template with the
	// length fields patched in, passes payload bytes through, keeps the running
	// CRC, and appends the CRC and tail when a frame closes. A start command that
	// follows payload without a closing byte simply begins a new header, which
	// abandons the previous frame.
	lsfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (q_cmd),
		.cmd_pop    (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.frame_end  (frame_end)
	);

endmodule

[rtl/lsfb_front.sv]
module lsfb_front #(
	parameter int unsigned MAX_PAYLOAD = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      fifo_full,
	input  logic                      action,
	input  logic [lsfb_pkg::LEN_W-1:0] payload_length,
	input  logic [7:0]                data_byte,
	output logic                      cmd_push,
	output lsfb_pkg::cmd_t            cmd
);
	import lsfb_pkg::*;

	localparam int unsigned LEN_CAP = (MAX_PAYLOAD > LEN_LIMIT) ? LEN_LIMIT : MAX_PAYLOAD;

	logic             in_payload_q;
	logic [LEN_W-1:0] remaining_q;
	logic             accept;
	logic [LEN_W-1:0] len_sat;
	logic [LEN_W-1:0] rem_next;

	assign accept = push && !fifo_full;

	always_comb begin
		len_sat  = (32'(payload_length) > LEN_CAP) ? LEN_W'(LEN_CAP) : payload_length;
		rem_next = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;
		cmd.kind = (action == 1'b0) ? CMD_START : CMD_DATA;
		cmd.len  = len_sat;
		cmd.data = data_byte;
		cmd.last = (rem_next == '0);
		// A data transaction with no open frame is dropped here.
		cmd_push = accept && ((action == 1'b0) || in_payload_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			remaining_q  <= '0;
		end else if (accept) begin
			if (action == 1'b0) begin
				in_payload_q <= (len_sat != '0);
				remaining_q  <= len_sat;
			end else if (in_payload_q) begin
				remaining_q <= rem_next;
				if (rem_next == '0) begin
					in_payload_q <= 1'b0;
				end
			end
		end
	end

endmodule

[rtl/lsfb_cmd_fifo.sv]
module lsfb_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  lsfb_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output logic           rd_valid,
	output lsfb_pkg::cmd_t rd_cmd
);
	import lsfb_pkg::*;

	cmd_t                 slots_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full     = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slots_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/lsfb_back.sv]
module lsfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  lsfb_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           last_of_run,
	output logic           frame_end
);
	import lsfb_pkg::*;

	back_state_t      state_q;
	back_state_t      state_n;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_n;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_n;
	logic [15:0]      crc_q;
	logic [15:0]      crc_n;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             end_q;
	logic             can_load;
	logic             take;
	logic             produce;
	logic [7:0]       byte_n;
	logic             last_n;
	logic             end_n;

	assign can_load    = !out_valid_q || pop;
	assign cmd_pop     = take && can_load;
	assign empty       = !out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign frame_end   = end_q;

	always_comb begin
		take    = 1'b0;
		produce = 1'b0;
		state_n = state_q;
		idx_n   = idx_q;
		len_n   = len_q;
		crc_n   = crc_q;
		byte_n  = 8'h00;
		last_n  = 1'b0;
		end_n   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					take    = 1'b1;
					produce = 1'b1;
					if (cmd.kind == CMD_START) begin
						byte_n  = hdr_byte('0, cmd.len);
						crc_n   = '0;
						idx_n   = IDX_W'(1);
						len_n   = cmd.len;
						state_n = BK_HDR;
					end else begin
						byte_n  = cmd.data;
						crc_n   = crc_update(crc_q, cmd.data);
						last_n  = !cmd.last;
						state_n = cmd.last ? BK_CRC_LO : BK_IDLE;
					end
				end
			end
			BK_HDR: begin
				produce = 1'b1;
				byte_n  = hdr_byte(idx_q, len_q);
				if (32'(idx_q) >= CRC_FROM) begin
					crc_n = crc_update(crc_q, byte_n);
				end
				idx_n = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					last_n  = (len_q != '0);
					state_n = (len_q == '0) ? BK_CRC_LO : BK_IDLE;
				end
			end
			BK_CRC_LO: begin
				produce = 1'b1;
				byte_n  = crc_q[7:0];
				state_n = BK_CRC_HI;
			end
			BK_CRC_HI: begin
				produce = 1'b1;
				byte_n  = crc_q[15:8];
				state_n = BK_TAIL;
			end
			BK_TAIL: begin
				produce = 1'b1;
				byte_n  = TAIL_BYTE;
				last_n  = 1'b1;
				end_n   = 1'b1;
				state_n = BK_IDLE;
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			len_q       <= '0;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= produce;
			if (produce) begin
				state_q <= state_n;
				idx_q   <= idx_n;
				len_q   <= len_n;
				crc_q   <= crc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && produce) begin
			out_byte_q <= byte_n;
			last_q     <= last_n;
			end_q      <= end_n;
		end
	end

endmodule

[test/led_sign_frame_builder_crc16_core_tb.sv]
`timescale 1ns / 1ps

module led_sign_frame_builder_crc16_core_tb;

	import lsfb_pkg::*;

	// Frame layout as the sign expects it. The header is a fixed template with three
	// little-endian length fields patched in, and the CRC starts at offset 8.
	localparam int          MAX_LEN    = 1024;
	localparam int          HDR_BYTES  = 58;
	localparam int          CRC_START  = 8;
	localparam logic [7:0]  TAIL       = 8'h5A;
	localparam logic [15:0] POLY_REFL  = 16'hA001;
	localparam logic [15:0] LEN2_BIAS  = 16'd27;
	localparam logic [15:0] LEN1_EXTRA = 16'd9;
	localparam int          OFS_F1     = 20;
	localparam int          OFS_F2     = 29;
	localparam int          OFS_LEN    = 54;

	// Guard against a hung block. The slowest correct run has every transaction
	// produce a full header while the receiver sits in its longest stalls; this is
	// several times that.
	localparam int          CYCLE_LIMIT  = 1_500_000;
	localparam int          RANDOM_ITEMS = 410;
	localparam int          MAX_PRINTS   = 40;

	localparam logic [7:0] SIGN_HDR [HDR_BYTES] = '{
		8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'h01, 8'h00,
		8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h02,
		8'h00, 8'h00, 8'hA3, 8'h06, 8'h01, 8'h2D, 8'h00, 8'h00, 8'h01, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h0C, 8'h00, 8'h20, 8'h01, 8'h30, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h02,
		8'h03, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// One byte of the framed output stream, as the block should present it.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       fend;
	} frame_byte_t;

	// One row of the directed part. Where "typed" is set, the number of result bytes
	// and the final byte are obvious from the frame format and are written in here.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [10:0] len;
		logic [7:0]  data;
		bit          typed;
		logic [6:0]  n_res;
		logic [7:0]  last_b;
	} dir_row_t;

	localparam int N_ROWS = 20;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                push           = 1'b0;
	logic                action         = 1'b0;
	logic [LEN_W-1:0]    payload_length = '0;
	logic [7:0]          data_byte      = 8'h00;
	logic                pop            = 1'b0;
	logic                full;
	logic                empty;
	logic [7:0]          out_byte;
	logic                last_of_run;
	logic                frame_end;

	// Predicted frame state, kept apart from the block.
	bit                  frame_open;
	logic [10:0]         bytes_left;
	logic [15:0]         frame_crc;

	frame_byte_t         expected_bytes [$];
	frame_byte_t         oldest;
	int                  errors;
	int                  cycles;
	int                  items_sent;
	int                  burst_left;

	// Receiver stall pattern.
	int                  pop_mode;
	int                  pop_mode_left;
	int                  stall_left;

	dir_row_t directed_rows [N_ROWS] = '{
		// A data byte with no frame open is dropped.
		'{CMD_DATA,  11'd0,    8'hFF, 1'b1, 7'd0,  8'h00},
		// A zero-length frame closes at once with CRC and tail.
		'{CMD_START, 11'd0,    8'h00, 1'b1, 7'd61, TAIL},
		'{CMD_START, 11'd1,    8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_DATA,  11'd0,    8'h00, 1'b1, 7'd4,  TAIL},
		// The largest length field saturates; the next start abandons that frame.
		'{CMD_START, 11'd2047, 8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_START, 11'd3,    8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_DATA,  11'd0,    8'hFF, 1'b0, 7'd0,  8'h00},
		'{CMD_DATA,  11'd0,    8'h00, 1'b0, 7'd0,  8'h00},
		'{CMD_DATA,  11'd0,    8'hA5, 1'b1, 7'd4,  TAIL},
		// Exactly at the limit, then just above it.
		'{CMD_START, 11'd1024, 8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_START, 11'd2,    8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_DATA,  11'd0,    8'h5A, 1'b0, 7'd0,  8'h00},
		'{CMD_DATA,  11'd0,    8'h80, 1'b1, 7'd4,  TAIL},
		'{CMD_START, 11'd1025, 8'h00, 1'b1, 7'd58, 8'h00},
		// Abandoning a frame in favor of a zero-length one.
		'{CMD_START, 11'd0,    8'h00, 1'b1, 7'd61, TAIL},
		'{CMD_DATA,  11'd0,    8'h12, 1'b1, 7'd0,  8'h00},
		'{CMD_START, 11'd1,    8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_START, 11'd1,    8'h00, 1'b1, 7'd58, 8'h00},
		'{CMD_DATA,  11'd0,    8'h7F, 1'b1, 7'd4,  TAIL},
		'{CMD_DATA,  11'd0,    8'h01, 1'b1, 7'd0,  8'h00}
	};

	led_sign_frame_builder_crc16_core #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.payload_length(payload_length),
		.data_byte     (data_byte),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.frame_end     (frame_end)
	);

	always #4 clk = ~clk;

	// Reflected CRC-16 over one byte, least significant bit first.
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		repeat (8) begin
			acc = acc[0] ? ((acc >> 1) ^ POLY_REFL) : (acc >> 1);
		end
		return acc;
	endfunction

	// Header byte at offset idx for an already saturated payload length.
	function automatic logic [7:0] sign_hdr_byte(input int idx, input logic [10:0] plen);
		logic [15:0] len2;
		logic [15:0] len1;
		len2 = {5'b0, plen} + LEN2_BIAS;
		len1 = len2 + LEN1_EXTRA;
		case (idx)
			OFS_F1:      return len1[7:0];
			OFS_F1 + 1:  return len1[15:8];
			OFS_F2:      return len2[7:0];
			OFS_F2 + 1:  return len2[15:8];
			OFS_LEN:     return plen[7:0];
			OFS_LEN + 1: return {5'b0, plen[10:8]};
			OFS_LEN + 2: return 8'h00;
			OFS_LEN + 3: return 8'h00;
			default:     return SIGN_HDR[idx];
		endcase
	endfunction

	task automatic queue_crc_and_tail();
		expected_bytes.push_back('{frame_crc[7:0], 1'b0, 1'b0});
		expected_bytes.push_back('{frame_crc[15:8], 1'b0, 1'b0});
		expected_bytes.push_back('{TAIL, 1'b1, 1'b1});
		frame_open = 1'b0;
		bytes_left = '0;
	endtask

	// Advances the predicted frame state by one accepted transaction and queues the
	// result bytes it should cause. Returns their number and the final byte.
	task automatic frame_model_step(input cmd_kind_t kind, input logic [10:0] len,
	                                input logic [7:0] d, output int n, output logic [7:0] fb);
		logic [10:0] plen;
		logic [7:0]  hb;
		int          queued_at_entry;
		queued_at_entry = expected_bytes.size();
		fb = 8'h00;
		if (kind == CMD_START) begin
			plen = (len > MAX_LEN) ? 11'(MAX_LEN) : len;
			frame_crc = 16'h0000;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hb = sign_hdr_byte(i, plen);
				if (i >= CRC_START) begin
					frame_crc = crc16_next(frame_crc, hb);
				end
				expected_bytes.push_back('{hb, (plen != 0 && i == HDR_BYTES - 1), 1'b0});
			end
			if (plen == 0) begin
				queue_crc_and_tail();
			end else begin
				frame_open = 1'b1;
				bytes_left = plen;
			end
		end else if (frame_open) begin
			frame_crc = crc16_next(frame_crc, d);
			if (bytes_left != 0) begin
				bytes_left = bytes_left - 1'b1;
			end
			if (bytes_left == 0) begin
				expected_bytes.push_back('{d, 1'b0, 1'b0});
				queue_crc_and_tail();
			end else begin
				expected_bytes.push_back('{d, 1'b1, 1'b0});
			end
		end
		n = expected_bytes.size() - queued_at_entry;
		if (n > 0) begin
			fb = expected_bytes[$].b;
		end
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("cycle %0d: mismatch: %s", cycles, msg);
		end
	endtask

	// Offers one transaction and waits for the block to take it. The push stays high
	// afterwards so that a burst runs back to back; only a gap lowers it.
	task automatic send_item(input cmd_kind_t kind, input logic [10:0] len,
	                         input logic [7:0] d, output int n, output logic [7:0] fb);
		bit counts;
		counts = (kind == CMD_START) || frame_open;
		push <= 1'b1;
		action <= kind;
		payload_length <= len;
		data_byte <= d;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		frame_model_step(kind, len, d, n, fb);
		if (counts) begin
			items_sent++;
		end
		burst_left--;
		if (burst_left <= 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Holds the sender back until every queued result byte has been taken.
	task automatic wait_all_results();
		push <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_payload_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Cycle count and the hang guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side. A transaction is taken at an edge where pop is high and empty is
	// low; the byte is checked against the oldest prediction right there. The pop
	// pattern then moves through phases: always ready, coin-flip, and long stalls.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h", out_byte));
			end else begin
				oldest = expected_bytes.pop_front();
				if (out_byte !== oldest.b) begin
					report_mismatch($sformatf("out_byte %02h, predicted %02h",
						out_byte, oldest.b));
				end
				if (last_of_run !== oldest.last) begin
					report_mismatch($sformatf("last_of_run %b, predicted %b",
						last_of_run, oldest.last));
				end
				if (frame_end !== oldest.fend) begin
					report_mismatch($sformatf("frame_end %b, predicted %b",
						frame_end, oldest.fend));
				end
			end
		end

		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop_mode_left <= 0) begin
				pop_mode = $urandom_range(0, 2);
				pop_mode_left = $urandom_range(100, 400);
			end else begin
				pop_mode_left--;
			end
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						pop <= 1'b0;
					end else begin
						pop <= 1'b1;
						if ($urandom_range(0, 5) == 0) begin
							stall_left = $urandom_range(1, 12);
						end
					end
				end
			endcase
		end
	end

	// Send side: reset once, the directed table, then random frames.
	initial begin
		int          n;
		int          pick;
		int          n_data;
		int          frames;
		logic [10:0] flen;
		logic [7:0]  fb;
		bit          abandon;

		errors = 0;
		items_sent = 0;
		frames = 0;
		frame_open = 1'b0;
		bytes_left = '0;
		frame_crc = 16'h0000;
		burst_left = $urandom_range(1, 40);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			send_item(directed_rows[r].kind, directed_rows[r].len, directed_rows[r].data,
				n, fb);
			if (directed_rows[r].typed) begin
				if (n != directed_rows[r].n_res ||
				    (n > 0 && fb !== directed_rows[r].last_b)) begin
					report_mismatch($sformatf("directed row %0d: %0d bytes ending %02h",
						r, n, fb));
				end
			end
		end

		// Once with nothing in flight before the random part begins.
		wait_all_results();

		// Random part: mostly complete frames of short length with random payload, some
		// abandoned by a new start, some saturating, and a little idle noise between.
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 8) begin
				send_item(CMD_DATA, 11'($urandom_range(0, 2047)), random_payload_byte(),
					n, fb);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					flen = 11'($urandom_range(MAX_LEN, 2047));
				end else if (pick < 15) begin
					flen = 11'($urandom_range(13, 60));
				end else if (pick < 25) begin
					flen = 11'd0;
				end else begin
					flen = 11'($urandom_range(1, 12));
				end
				abandon = (flen > 60) || ($urandom_range(0, 7) == 0);
				if (flen == 0) begin
					n_data = 0;
				end else if (abandon) begin
					n_data = $urandom_range(0, (flen < 6) ? flen - 1 : 6);
				end else begin
					n_data = flen;
				end
				send_item(CMD_START, flen, 8'($urandom_range(0, 255)), n, fb);
				for (int k = 0; k < n_data; k++) begin
					send_item(CMD_DATA, 11'($urandom_range(0, 2047)), random_payload_byte(),
						n, fb);
				end
				frames++;
				if (frames == 10 || $urandom_range(0, 24) == 0) begin
					wait_all_results();
				end
			end
		end

		// Drain, then give the block time to show any stray result byte.
		wait_all_results();
		repeat (64) @(posedge clk);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[led_sign_frame_builder_crc16_core.f]
rtl/lsfb_pkg.sv
rtl/lsfb_front.sv
rtl/lsfb_cmd_fifo.sv
rtl/lsfb_back.sv
rtl/led_sign_frame_builder_crc16_core.sv
test/led_sign_frame_builder_crc16_core_tb.sv
